// File: src/assert_macros.svh
// Assertion shorthands shared by the filter's modules. Each macro checks on the
// rising edge of i_clk and is switched off while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define BNF_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define BNF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/bnf_pkg.sv
`default_nettype none

package bnf_pkg;

    localparam int COEF_W   = 24;
    localparam int SAMPLE_W = 14;
    localparam int Y_W      = 32;
    localparam int CODE_W   = 12;
    localparam int ADDR_W   = 5;
    localparam int DATA_W   = 32;
    localparam int IDX_W    = 3;

    typedef logic signed [COEF_W-1:0] t_coef;

    // Coefficient set handed from the register file to the datapath.
    typedef struct packed {
        t_coef b2;
        t_coef b1;
        t_coef b0;
        t_coef a1;
        t_coef a0;
    } t_coefs;

    // Register indexes (byte address divided by four).
    localparam logic [IDX_W-1:0] REG_B2 = 3'd0;
    localparam logic [IDX_W-1:0] REG_B1 = 3'd1;
    localparam logic [IDX_W-1:0] REG_B0 = 3'd2;
    localparam logic [IDX_W-1:0] REG_A1 = 3'd3;
    localparam logic [IDX_W-1:0] REG_A0 = 3'd4;

    // Reset coefficients give a notch (Q3.20).
    localparam t_coef B2_RESET = 24'sh100000;   //  1.0
    localparam t_coef B1_RESET = 24'shE08F5C;   // -1.965
    localparam t_coef B0_RESET = 24'sh0FFF97;   //  0.9999
    localparam t_coef A1_RESET = 24'shE0B852;   // -1.955
    localparam t_coef A0_RESET = 24'sh0FD70A;   //  0.99

    localparam logic signed [Y_W-1:0] Y_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [Y_W-1:0] Y_MIN = 32'sh8000_0000;

    localparam logic [CODE_W-1:0] CODE_MIN = 12'h000;
    localparam logic [CODE_W-1:0] CODE_MAX = 12'hFFF;

endpackage

`default_nettype wire

// File: src/biquad_notch_filter_unit.sv
// Notch filter for a converter sample stream: one direct form I biquad section,
// y = b2*u + b1*u1 + b0*u2 - a1*y1 - a0*y2. Each item is a 14-bit sample taken as
// Q12.2; the filter output is kept in signed Q23.8, saturated to 32 bits, and the
// item delivered is its floor clamped to the 12-bit DAC range 0..4095, with a flag
// that is set whenever the clamp was applied. The five Q3.20 coefficients sit in
// an APB register file at byte addresses 0x00 (b2), 0x04 (b1), 0x08 (b0), 0x0C
// (a1) and 0x10 (a0); only the low 24 bits of a write are kept, reads return the
// value sign-extended, and the reset values form a notch. The block sustains one
// item per clock cycle while the output side does not stall: the two output delay
// registers close the recursion, so all five products and their sum are formed
// combinationally between the input register and the result register. The item in
// the input register moves into the result register when the output does not stall.
// Coefficients should only be changed while no item is in flight.

`default_nettype none

`include "assert_macros.svh"

module biquad_notch_filter_unit
    import bnf_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,

    // Sample input channel.
    input  wire logic                i_in_valid,
    output      logic                o_in_stall,
    input  wire logic [SAMPLE_W-1:0] i_adc_sample,

    // Result channel.
    output      logic                o_out_valid,
    input  wire logic                i_out_stall,
    output      logic [CODE_W-1:0]   o_dac_code,
    output      logic                o_clipped,

    // Coefficient register port.
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [ADDR_W-1:0]   paddr,
    input  wire logic [DATA_W-1:0]   pwdata,
    output      logic [DATA_W-1:0]   prdata,
    output      logic                pready
);

    t_coefs              w_coefs;

    // Input register.
    logic                r_in_valid;
    logic                n_in_valid;
    logic [SAMPLE_W-1:0] r_sample;

    // Result register.
    logic                r_out_valid;
    logic                n_out_valid;
    logic [CODE_W-1:0]   r_code;
    logic                r_clip;

    logic                w_in_accept;
    logic                w_advance;
    logic [CODE_W-1:0]   w_code;
    logic                w_clip;

    bnf_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_coefs (w_coefs)
    );

    // The item in the input register moves on whenever the result register is
    // empty or is being emptied in this cycle. That same move updates the
    // filter's delay line, so the state advances exactly once per item.
    assign w_advance   = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall  = r_in_valid && !w_advance;
    assign w_in_accept = i_in_valid && !o_in_stall;

    bnf_datapath u_datapath (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (w_advance),
        .i_sample  (r_sample),
        .i_coefs   (w_coefs),
        .o_code    (w_code),
        .o_clip    (w_clip)
    );

    always_comb begin
        n_in_valid = r_in_valid;
        if (w_in_accept) begin
            n_in_valid = 1'b1;
        end else if (w_advance) begin
            n_in_valid = 1'b0;
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_advance) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_sample <= i_adc_sample;
        end
        if (w_advance) begin
            r_code <= w_code;
            r_clip <= w_clip;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_dac_code  = r_code;
    assign o_clipped   = r_clip;

    `BNF_ASSERT_IMPL(a_clip_at_rail, r_out_valid && r_clip,
        r_code == CODE_MIN || r_code == CODE_MAX, "clip flag set away from a rail")
    `BNF_ASSERT_NEXT(a_advance_fills_out, w_advance,
        r_out_valid, "item moved on but no result is held")
    `BNF_ASSERT_NEXT(a_blocked_item_held, r_in_valid && !w_advance,
        r_in_valid && $stable(r_sample), "blocked input item was lost or changed")

endmodule

`default_nettype wire

// File: src/bnf_regs.sv
`default_nettype none

module bnf_regs
    import bnf_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output      logic [DATA_W-1:0] prdata,
    output      logic              pready,
    output      t_coefs            o_coefs
);

    t_coefs             r_coefs;
    t_coefs             n_coefs;
    logic [IDX_W-1:0]   w_idx;
    logic               w_wr;
    t_coef              w_rd;

    assign w_idx  = paddr[ADDR_W-1:2];
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;

    always_comb begin
        n_coefs = r_coefs;
        if (w_wr) begin
            unique case (w_idx)
                REG_B2:  n_coefs.b2 = pwdata[COEF_W-1:0];
                REG_B1:  n_coefs.b1 = pwdata[COEF_W-1:0];
                REG_B0:  n_coefs.b0 = pwdata[COEF_W-1:0];
                REG_A1:  n_coefs.a1 = pwdata[COEF_W-1:0];
                REG_A0:  n_coefs.a0 = pwdata[COEF_W-1:0];
                default: n_coefs    = r_coefs;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coefs.b2 <= B2_RESET;
            r_coefs.b1 <= B1_RESET;
            r_coefs.b0 <= B0_RESET;
            r_coefs.a1 <= A1_RESET;
            r_coefs.a0 <= A0_RESET;
        end else begin
            r_coefs <= n_coefs;
        end
    end

    // Reads return the coefficient sign-extended to the bus width.
    always_comb begin
        unique case (w_idx)
            REG_B2:  w_rd = r_coefs.b2;
            REG_B1:  w_rd = r_coefs.b1;
            REG_B0:  w_rd = r_coefs.b0;
            REG_A1:  w_rd = r_coefs.a1;
            REG_A0:  w_rd = r_coefs.a0;
            default: w_rd = '0;
        endcase
    end

    assign prdata  = DATA_W'(w_rd);
    assign o_coefs = r_coefs;

endmodule

`default_nettype wire

// File: src/bnf_datapath.sv
`default_nettype none

`include "assert_macros.svh"

module bnf_datapath
    import bnf_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_advance,
    input  wire logic [SAMPLE_W-1:0] i_sample,
    input  wire t_coefs              i_coefs,
    output      logic [CODE_W-1:0]   o_code,
    output      logic                o_clip
);

    // Delay line: samples in Q12.2, outputs in signed Q23.8.
    logic        [SAMPLE_W-1:0] r_u1;
    logic        [SAMPLE_W-1:0] r_u2;
    logic signed [Y_W-1:0]      r_y1;
    logic signed [Y_W-1:0]      r_y2;

    logic signed [SAMPLE_W:0]   w_s0;
    logic signed [SAMPLE_W:0]   w_s1;
    logic signed [SAMPLE_W:0]   w_s2;
    logic signed [38:0]         w_p_b2;
    logic signed [38:0]         w_p_b1;
    logic signed [38:0]         w_p_b0;
    logic signed [55:0]         w_p_a1;
    logic signed [55:0]         w_p_a0;
    logic signed [40:0]         w_ff;
    logic signed [46:0]         w_ff_scaled;
    logic signed [56:0]         w_fb;
    logic signed [57:0]         w_acc;
    logic signed [37:0]         w_y_wide;
    logic signed [Y_W-1:0]      w_y;
    logic signed [23:0]         w_code_wide;

    assign w_s0 = $signed({1'b0, i_sample});
    assign w_s1 = $signed({1'b0, r_u1});
    assign w_s2 = $signed({1'b0, r_u2});

    assign w_p_b2 = $signed(i_coefs.b2) * w_s0;
    assign w_p_b1 = $signed(i_coefs.b1) * w_s1;
    assign w_p_b0 = $signed(i_coefs.b0) * w_s2;
    assign w_p_a1 = $signed(i_coefs.a1) * r_y1;
    assign w_p_a0 = $signed(i_coefs.a0) * r_y2;

    // Feed-forward has 22 fraction bits; shifting by six aligns it with the
    // 28 fraction bits of the feedback products.
    assign w_ff        = 41'(w_p_b2) + 41'(w_p_b1) + 41'(w_p_b0);
    assign w_ff_scaled = $signed({w_ff, 6'b0});
    assign w_fb        = 57'(w_p_a1) + 57'(w_p_a0);
    assign w_acc       = 58'(w_ff_scaled) - 58'(w_fb);

    // Dropping the low 20 bits of a two's complement value is a floor.
    assign w_y_wide = w_acc[57:20];

    always_comb begin
        if ((&w_y_wide[37:31]) || !(|w_y_wide[37:31])) begin
            w_y = w_y_wide[Y_W-1:0];
        end else if (w_y_wide[37]) begin
            w_y = Y_MIN;
        end else begin
            w_y = Y_MAX;
        end
    end

    assign w_code_wide = w_y[Y_W-1:8];

    always_comb begin
        priority if (w_code_wide[23]) begin
            o_code = CODE_MIN;
            o_clip = 1'b1;
        end else if (|w_code_wide[22:CODE_W]) begin
            o_code = CODE_MAX;
            o_clip = 1'b1;
        end else begin
            o_code = w_code_wide[CODE_W-1:0];
            o_clip = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_u1 <= '0;
            r_u2 <= '0;
            r_y1 <= '0;
            r_y2 <= '0;
        end else if (i_advance) begin
            r_u1 <= i_sample;
            r_u2 <= r_u1;
            r_y1 <= w_y;
            r_y2 <= r_y1;
        end
    end

    `BNF_ASSERT_NEXT(a_delay_shift, i_advance,
        r_u2 == $past(r_u1) && r_y2 == $past(r_y1), "delay line did not shift on an item")
    `BNF_ASSERT_NEXT(a_delay_hold, !i_advance,
        $stable(r_u1) && $stable(r_y1) && $stable(r_y2), "delay line moved without an item")

endmodule

`default_nettype wire
